### rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master register access block.
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

   // Command codes carried by the func field
   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_RSVD  = 2'd3
   } func_type;

   // Sequencer steps; each step holds the line levels set on entering it for a phase
   typedef enum logic [4:0] {
      ST_IDLE        = 5'd0,
      ST_PREP_LOW    = 5'd1,
      ST_PREP_SDA_HI = 5'd2,
      ST_PREP_SCL_HI = 5'd3,
      ST_START       = 5'd4,
      ST_TX_BIT_LO   = 5'd5,
      ST_TX_BIT_HI   = 5'd6,
      ST_TX_ACK_LO   = 5'd7,
      ST_TX_ACK_REL  = 5'd8,
      ST_TX_ACK_HI   = 5'd9,
      ST_TX_ACK_END  = 5'd10,
      ST_TX_HOLD     = 5'd11,
      ST_RX_BEGIN    = 5'd12,
      ST_RX_BIT_LO   = 5'd13,
      ST_RX_BIT_HI   = 5'd14,
      ST_RX_ACK_LO   = 5'd15,
      ST_RX_NACK     = 5'd16,
      ST_RX_ACK_HI   = 5'd17,
      ST_RX_ACK_END  = 5'd18,
      ST_STOP_LO     = 5'd19,
      ST_STOP_SDA_LO = 5'd20,
      ST_STOP_SCL_HI = 5'd21,
      ST_STOP_SDA_HI = 5'd22
   } step_type;

   localparam logic [15:0] PHASE_TICKS_RESET = 16'd15;
   localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

   // Byte counter values of the transfer
   localparam logic [2:0] BC_DEV     = 3'd0;
   localparam logic [2:0] BC_REG     = 3'd1;
   localparam logic [2:0] BC_THIRD   = 3'd2;
   localparam logic [2:0] BC_RX_ONE  = 3'd3;
   localparam logic [2:0] BC_RX_TWO  = 3'd4;

   // One input beat
   typedef struct packed {
      logic [1:0] func;
      logic [7:0] device_addr;
      logic [7:0] reg_addr;
      logic [7:0] write_data;
      logic       low_byte_first;
      logic       sda_in;
   } item_type;

   // Latched command
   typedef struct packed {
      logic       order;
      logic [7:0] data;
      logic [7:0] regs;
      logic [7:0] dev;
      logic [1:0] func;
   } cmd_type;

   // Driven line levels
   typedef struct packed {
      logic scl;
      logic sda;
      logic en;
   } lines_type;

   // One result beat
   typedef struct packed {
      logic        scl;
      logic        sda_level;
      logic        sda_enable;
      logic        busy_res;
      logic        done_res;
      logic        read_ok;
      logic [15:0] read_word;
   } result_type;

endpackage

`default_nettype wire

### rtl/i2cm_if.sv
// Valid/ready channel interfaces: request, response and register write.
`timescale 1ns / 1ps
`default_nettype none

interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] device_addr;
   logic [7:0] reg_addr;
   logic [7:0] write_data;
   logic       low_byte_first;
   logic       sda_in;

   modport source (output valid, func, device_addr, reg_addr, write_data,
                   low_byte_first, sda_in, input ready);
   modport sink (input valid, func, device_addr, reg_addr, write_data,
                 low_byte_first, sda_in, output ready);
endinterface

interface i2cm_rsp_if;
   logic        valid;
   logic        ready;
   logic        scl;
   logic        sda_level;
   logic        sda_enable;
   logic        busy_res;
   logic        done_res;
   logic        read_ok;
   logic [15:0] read_word;

   modport source (output valid, scl, sda_level, sda_enable, busy_res, done_res,
                   read_ok, read_word, input ready);
   modport sink (input valid, scl, sda_level, sda_enable, busy_res, done_res,
                 read_ok, read_word, output ready);
endinterface

interface i2cm_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

### rtl/i2cm_core.sv
// I2C sequencer state and its one-tick update; result reflects the updated state.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_core
   import i2cm_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         enable,
   input  item_type    item,
   input  wire  [15:0] phase_ticks,
   output result_type  res
);

   step_type    step_ff, step_in;
   logic [15:0] timer_ff, timer_in;
   logic [3:0]  bit_ff, bit_in;
   logic [2:0]  byte_ff, byte_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] word_ff, word_in;
   cmd_type     cmd_ff, cmd_in;
   logic        ack_ff, ack_in;
   lines_type   lines_ff, lines_in;

   logic [15:0] limit;
   logic        enter_en;
   logic        done;
   logic [3:0]  bit_inc;
   logic [2:0]  byte_inc;
   logic        rx_first;

   // Byte sent for a given byte count
   function automatic logic [7:0] tx_byte(input cmd_type c, input logic [2:0] bc);
      logic [7:0] b;
      if (bc == BC_DEV) b = c.dev;
      else if (bc == BC_REG) b = c.regs;
      else if (c.func == FUNC_WRITE) b = c.data;
      else b = c.dev + 8'd1;
      return b;
   endfunction

   assign limit    = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
   assign bit_inc  = bit_ff + 4'd1;
   assign byte_inc = byte_ff + 3'd1;
   assign rx_first = (byte_ff == BC_RX_ONE);

   // Step transition and datapath update for one tick
   always_comb begin
      step_in  = step_ff;
      timer_in = timer_ff;
      bit_in   = bit_ff;
      byte_in  = byte_ff;
      shift_in = shift_ff;
      word_in  = word_ff;
      cmd_in   = cmd_ff;
      ack_in   = ack_ff;
      enter_en = 1'b0;
      done     = 1'b0;
      if (step_ff == ST_IDLE) begin
         if (item.func == FUNC_WRITE || item.func == FUNC_READ) begin
            cmd_in.func  = item.func;
            cmd_in.dev   = item.device_addr;
            cmd_in.regs  = item.reg_addr;
            cmd_in.data  = item.write_data;
            cmd_in.order = item.low_byte_first;
            byte_in  = BC_DEV;
            bit_in   = 4'd0;
            step_in  = ST_PREP_LOW;
            enter_en = 1'b1;
         end
      end else if (timer_ff >= limit) begin
         enter_en = 1'b1;
         case (step_ff)
            ST_START: begin
               shift_in = tx_byte(cmd_ff, byte_ff);
               bit_in   = 4'd0;
               step_in  = ST_TX_BIT_LO;
            end
            ST_TX_BIT_HI: begin
               bit_in   = bit_inc;
               shift_in = {shift_ff[6:0], 1'b0};
               step_in  = (bit_inc < BITS_PER_BYTE) ? ST_TX_BIT_LO : ST_TX_ACK_LO;
            end
            ST_TX_ACK_HI: begin
               if (cmd_ff.func == FUNC_READ && byte_ff == BC_THIRD)
                  ack_in = ~item.sda_in;
               step_in = ST_TX_ACK_END;
            end
            ST_TX_HOLD: begin
               if (cmd_ff.func == FUNC_WRITE) begin
                  if (byte_ff < BC_THIRD) begin
                     byte_in  = byte_inc;
                     shift_in = tx_byte(cmd_ff, byte_inc);
                     bit_in   = 4'd0;
                     step_in  = ST_TX_BIT_LO;
                  end else begin
                     step_in = ST_STOP_LO;
                  end
               end else if (byte_ff == BC_DEV) begin
                  byte_in  = BC_REG;
                  shift_in = tx_byte(cmd_ff, BC_REG);
                  bit_in   = 4'd0;
                  step_in  = ST_TX_BIT_LO;
               end else if (byte_ff == BC_REG) begin
                  byte_in = BC_THIRD;
                  step_in = ST_PREP_LOW;
               end else if (ack_ff) begin
                  byte_in = BC_RX_ONE;
                  step_in = ST_RX_BEGIN;
               end else begin
                  step_in = ST_STOP_LO;
               end
            end
            ST_RX_BEGIN: begin
               bit_in  = 4'd0;
               step_in = ST_RX_BIT_LO;
            end
            ST_RX_BIT_HI: begin
               shift_in = {shift_ff[6:0], item.sda_in};
               bit_in   = bit_inc;
               step_in  = (bit_inc < BITS_PER_BYTE) ? ST_RX_BIT_LO : ST_RX_ACK_LO;
            end
            ST_RX_ACK_LO: begin
               // first byte lands high unless low-first order, second the reverse
               if (rx_first ^ cmd_ff.order) word_in = {shift_ff, word_ff[7:0]};
               else word_in = {word_ff[15:8], shift_ff};
               step_in = rx_first ? ST_RX_ACK_HI : ST_RX_NACK;
            end
            ST_RX_ACK_END: begin
               if (rx_first) begin
                  byte_in = BC_RX_TWO;
                  step_in = ST_RX_BEGIN;
               end else begin
                  step_in = ST_STOP_LO;
               end
            end
            ST_STOP_SDA_HI: begin
               step_in  = ST_IDLE;
               timer_in = 16'd0;
               enter_en = 1'b0;
               done     = 1'b1;
            end
            default: begin
               if (step_ff >= ST_PREP_LOW && step_ff < ST_STOP_SDA_HI) begin
                  step_in = step_type'(step_ff + 5'd1);
               end else begin
                  step_in  = ST_IDLE;
                  timer_in = 16'd0;
                  enter_en = 1'b0;
               end
            end
         endcase
      end else begin
         timer_in = timer_ff + 16'd1;
      end
      if (enter_en) timer_in = 16'd1;
   end

   // Line changes made on entering a step
   always_comb begin
      lines_in = lines_ff;
      if (enter_en) begin
         case (step_in)
            ST_PREP_LOW:    begin lines_in.scl = 1'b0; lines_in.en = 1'b1; end
            ST_PREP_SDA_HI: begin lines_in.sda = 1'b1; lines_in.en = 1'b1; end
            ST_PREP_SCL_HI: lines_in.scl = 1'b1;
            ST_START:       lines_in.sda = 1'b0;
            ST_TX_BIT_LO: begin
               lines_in.scl = 1'b0;
               lines_in.sda = shift_in[7];
               lines_in.en  = 1'b1;
            end
            ST_TX_BIT_HI:   lines_in.scl = 1'b1;
            ST_TX_ACK_LO:   lines_in.scl = 1'b0;
            ST_TX_ACK_REL:  lines_in.en  = 1'b0;
            ST_TX_ACK_HI:   lines_in.scl = 1'b1;
            ST_TX_ACK_END:  lines_in.scl = 1'b0;
            ST_TX_HOLD:     begin lines_in.en = 1'b1; lines_in.sda = 1'b0; end
            ST_RX_BEGIN:    begin lines_in.scl = 1'b0; lines_in.en = 1'b0; end
            ST_RX_BIT_LO:   lines_in.scl = 1'b0;
            ST_RX_BIT_HI:   lines_in.scl = 1'b1;
            ST_RX_ACK_LO: begin
               lines_in.scl = 1'b0;
               lines_in.en  = 1'b1;
               lines_in.sda = 1'b0;
            end
            ST_RX_NACK:     lines_in.sda = 1'b1;
            ST_RX_ACK_HI:   lines_in.scl = 1'b1;
            ST_RX_ACK_END:  lines_in.scl = 1'b0;
            ST_STOP_LO:     lines_in.scl = 1'b0;
            ST_STOP_SDA_LO: begin lines_in.sda = 1'b0; lines_in.en = 1'b1; end
            ST_STOP_SCL_HI: lines_in.scl = 1'b1;
            ST_STOP_SDA_HI: lines_in.sda = 1'b1;
            default:        lines_in = lines_ff;
         endcase
      end
   end

   // Result as seen after this tick
   always_comb begin
      res.scl        = lines_in.scl;
      res.sda_level  = lines_in.sda;
      res.sda_enable = lines_in.en;
      res.busy_res   = (step_in != ST_IDLE);
      res.done_res   = done;
      res.read_ok    = ack_in;
      res.read_word  = word_in;
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= ST_IDLE;
         timer_ff <= 16'd0;
         bit_ff   <= 4'd0;
         byte_ff  <= BC_DEV;
         shift_ff <= 8'd0;
         word_ff  <= 16'd0;
         cmd_ff   <= '0;
         ack_ff   <= 1'b0;
         lines_ff <= '{scl: 1'b1, sda: 1'b1, en: 1'b1};
      end else if (enable) begin
         step_ff  <= step_in;
         timer_ff <= timer_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         shift_ff <= shift_in;
         word_ff  <= word_in;
         cmd_ff   <= cmd_in;
         ack_ff   <= ack_in;
         lines_ff <= lines_in;
      end
   end

endmodule

`default_nettype wire

### rtl/i2c_master_register_access.sv
// Top level: I2C master register access sequencer with beat pipeline.
// Pipeline: two register stages. An accepted request beat sits in the input register;
// the sequencer update lands in the output register once it is free, and the response
// beat is held there until taken. Throughput: one request beat per cycle unless the
// response channel stalls; the sequencer advances one tick per beat.
// Reset (synchronous, active high): sequencer idle, lines high and driven,
// phase length 15 ticks, pipeline empty.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_register_access
   import i2cm_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   i2cm_req_if.sink     req_chan,
   i2cm_rsp_if.source   rsp_chan,
   i2cm_csr_if.sink     csr_chan
);

   logic        s1_valid_ff, s1_valid_in;
   item_type    s1_item_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff;
   logic [15:0] phase_ticks_ff;

   logic        out_free;
   logic        s1_fire;
   logic        req_take;
   item_type    req_item;
   result_type  core_res;

   // Pipeline handshake
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_fire        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign req_item = '{func: req_chan.func, device_addr: req_chan.device_addr,
                       reg_addr: req_chan.reg_addr, write_data: req_chan.write_data,
                       low_byte_first: req_chan.low_byte_first, sda_in: req_chan.sda_in};

   always_comb begin
      if (req_take) s1_valid_in = 1'b1;
      else if (s1_fire) s1_valid_in = 1'b0;
      else s1_valid_in = s1_valid_ff;
      if (s1_fire) rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ticks_ff <= PHASE_TICKS_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) phase_ticks_ff <= csr_chan.data;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) s1_item_ff <= req_item;
      if (s1_fire) rsp_data_ff <= core_res;
   end

   i2cm_core u_core (
      .clock       (clock),
      .reset       (reset),
      .enable      (s1_fire),
      .item        (s1_item_ff),
      .phase_ticks (phase_ticks_ff),
      .res         (core_res)
   );

   // Response beat
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.scl        = rsp_data_ff.scl;
   assign rsp_chan.sda_level  = rsp_data_ff.sda_level;
   assign rsp_chan.sda_enable = rsp_data_ff.sda_enable;
   assign rsp_chan.busy_res   = rsp_data_ff.busy_res;
   assign rsp_chan.done_res   = rsp_data_ff.done_res;
   assign rsp_chan.read_ok    = rsp_data_ff.read_ok;
   assign rsp_chan.read_word  = rsp_data_ff.read_word;

endmodule

`default_nettype wire
